/* design/cpexc_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the coprocessor exception unit
package cpexc_pkg;

  // transaction modes
  localparam logic [1:0] MODE_RAISE     = 2'd0;
  localparam logic [1:0] MODE_IRQ_SET   = 2'd1;
  localparam logic [1:0] MODE_IRQ_CLEAR = 2'd2;
  localparam logic [1:0] MODE_STATUS_WR = 2'd3;

  // synchronous exception kinds
  localparam logic [2:0] KIND_ADDR     = 3'd0;
  localparam logic [2:0] KIND_BUS      = 3'd1;
  localparam logic [2:0] KIND_OVF      = 3'd2;
  localparam logic [2:0] KIND_SYSCALL  = 3'd3;
  localparam logic [2:0] KIND_BREAK    = 3'd4;
  localparam logic [2:0] KIND_RESERVED = 3'd5;
  localparam logic [2:0] KIND_COP_UNUS = 3'd6;

  // next action of the cpu
  localparam logic [1:0] ACT_CONTINUE = 2'd0;
  localparam logic [1:0] ACT_DELAY    = 2'd1;
  localparam logic [1:0] ACT_JUMP     = 2'd2;

  // cause exception codes
  localparam logic [4:0] EXC_INT  = 5'd0;
  localparam logic [4:0] EXC_ADEL = 5'd4;
  localparam logic [4:0] EXC_ADES = 5'd5;
  localparam logic [4:0] EXC_IBE  = 5'd6;
  localparam logic [4:0] EXC_DBE  = 5'd7;
  localparam logic [4:0] EXC_SYS  = 5'd8;
  localparam logic [4:0] EXC_BP   = 5'd9;
  localparam logic [4:0] EXC_RI   = 5'd10;
  localparam logic [4:0] EXC_CPU  = 5'd11;
  localparam logic [4:0] EXC_OV   = 5'd12;

  localparam logic [31:0] STATUS_RESET = 32'h0060_0000;
  localparam logic [31:0] BOOT_BASE    = 32'hbfc0_0100;
  localparam logic [31:0] KSEG0_BASE   = 32'h8000_0000;
  localparam logic [31:0] VEC_OFFSET   = 32'h0000_0080;
  localparam logic [31:0] VEC_BOOT     = BOOT_BASE + VEC_OFFSET;
  localparam logic [31:0] VEC_KSEG0    = KSEG0_BASE + VEC_OFFSET;
  localparam int          SR_BEV_BIT   = 22;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  exc_kind;
    logic [31:0] fault_address;
    logic        from_fetch;
    logic        is_load;
    logic [1:0]  coproc_index;
    logic [2:0]  irq_line;
    logic [31:0] status_write_value;
    logic [31:0] current_pc;
    logic [1:0]  next_action;
    logic [31:0] jump_target;
    logic        in_delay_slot;
  } item_t;

endpackage

/* design/coprocessor_exception_unit.sv */
`timescale 1ns / 1ps
// coprocessor-0 exception entry: status, cause, epc and bad-address registers
//
// Each input transaction raises a synchronous exception, sets or clears one
// pending interrupt line, or writes the status register; it yields exactly one
// result transaction carrying whether an exception was entered, the handler
// vector (zero when none) and the four registers as they stand after it.
// After an irq set or a status write, an enabled (IEc) and unmasked (IM & IP)
// interrupt is entered with the resume pc taken from next_action; a clear never
// enters one. Exception kind 7 is ignored and changes nothing. Entry pushes the
// KU/IE stack, writes ExcCode, CE and BD, loads EPC and picks 0xbfc00180 when
// BEV is set, else 0x80000080. Throughput is one transaction per clock while
// out_ready lets the result drain; the accepting edge loads the input register
// and the compute stage then loads the result register together with the
// architectural registers. Both registers advance whenever the result register
// is free or being drained, so a stalled output holds at most two transactions
// inside the block.
module coprocessor_exception_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_exc_kind,
  input  logic [31:0] in_fault_address,
  input  logic        in_from_fetch,
  input  logic        in_is_load,
  input  logic [1:0]  in_coproc_index,
  input  logic [2:0]  in_irq_line,
  input  logic [31:0] in_status_write_value,
  input  logic [31:0] in_current_pc,
  input  logic [1:0]  in_next_action,
  input  logic [31:0] in_jump_target,
  input  logic        in_in_delay_slot,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_exception_taken,
  output logic [31:0] out_handler_address,
  output logic [31:0] out_epc_out,
  output logic [31:0] out_cause_out,
  output logic [31:0] out_status_out,
  output logic [31:0] out_bad_address_out
);

  // input register
  logic               s1_valid_r;
  cpexc_pkg::item_t   s1_item_r;

  // architectural registers
  logic [31:0] status_r, status_nxt;
  logic [31:0] cause_r, cause_nxt;
  logic [31:0] epc_r, epc_nxt;
  logic [31:0] badaddr_r, badaddr_nxt;

  // result register
  logic        out_valid_r;
  logic        out_taken_r;
  logic [31:0] out_handler_r;

  logic fire;

  // datapath signals
  logic [31:0] status_mid;
  logic [31:0] cause_mid;
  logic [7:0]  ip_bit;
  logic        exc_ok;
  logic        irq_take;
  logic        taken;
  logic [4:0]  code;
  logic [1:0]  ce;
  logic [31:0] epc_val;
  logic        bd_val;
  logic [4:0]  exc_code;

  // the compute stage moves when the result register is empty or draining
  assign fire     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.mode               <= in_mode;
      s1_item_r.exc_kind           <= in_exc_kind;
      s1_item_r.fault_address      <= in_fault_address;
      s1_item_r.from_fetch         <= in_from_fetch;
      s1_item_r.is_load            <= in_is_load;
      s1_item_r.coproc_index       <= in_coproc_index;
      s1_item_r.irq_line           <= in_irq_line;
      s1_item_r.status_write_value <= in_status_write_value;
      s1_item_r.current_pc         <= in_current_pc;
      s1_item_r.next_action        <= in_next_action;
      s1_item_r.jump_target        <= in_jump_target;
      s1_item_r.in_delay_slot      <= in_in_delay_slot;
    end
  end

  // synchronous exception code; unknown kind leaves everything alone
  always_comb begin
    exc_ok   = 1'b1;
    exc_code = cpexc_pkg::EXC_INT;
    case (s1_item_r.exc_kind)
      cpexc_pkg::KIND_ADDR:
        exc_code = s1_item_r.is_load ? cpexc_pkg::EXC_ADEL : cpexc_pkg::EXC_ADES;
      cpexc_pkg::KIND_BUS:
        exc_code = s1_item_r.from_fetch ? cpexc_pkg::EXC_IBE : cpexc_pkg::EXC_DBE;
      cpexc_pkg::KIND_OVF:      exc_code = cpexc_pkg::EXC_OV;
      cpexc_pkg::KIND_SYSCALL:  exc_code = cpexc_pkg::EXC_SYS;
      cpexc_pkg::KIND_BREAK:    exc_code = cpexc_pkg::EXC_BP;
      cpexc_pkg::KIND_RESERVED: exc_code = cpexc_pkg::EXC_RI;
      cpexc_pkg::KIND_COP_UNUS: exc_code = cpexc_pkg::EXC_CPU;
      default:                  exc_ok   = 1'b0;
    endcase
  end

  always_comb begin
    ip_bit = 8'b1 << s1_item_r.irq_line;

    // first effect of the transaction, before any interrupt check
    status_mid = status_r;
    cause_mid  = cause_r;
    case (s1_item_r.mode)
      cpexc_pkg::MODE_IRQ_SET:   cause_mid[15:8] = cause_r[15:8] | ip_bit;
      cpexc_pkg::MODE_IRQ_CLEAR: cause_mid[15:8] = cause_r[15:8] & ~ip_bit;
      cpexc_pkg::MODE_STATUS_WR: status_mid = s1_item_r.status_write_value;
      default: ;
    endcase

    irq_take = ((s1_item_r.mode == cpexc_pkg::MODE_IRQ_SET) ||
                (s1_item_r.mode == cpexc_pkg::MODE_STATUS_WR)) &&
               status_mid[0] && (|(status_mid[15:8] & cause_mid[15:8]));

    taken = irq_take || ((s1_item_r.mode == cpexc_pkg::MODE_RAISE) && exc_ok);

    // entry fields: interrupt resume pc comes from the next action
    if (s1_item_r.mode == cpexc_pkg::MODE_RAISE) begin
      code    = exc_code;
      ce      = (s1_item_r.exc_kind == cpexc_pkg::KIND_COP_UNUS) ?
                s1_item_r.coproc_index : 2'd0;
      bd_val  = s1_item_r.in_delay_slot;
      epc_val = s1_item_r.in_delay_slot ? (s1_item_r.current_pc - 32'd4)
                                        : s1_item_r.current_pc;
    end else begin
      code = cpexc_pkg::EXC_INT;
      ce   = 2'd0;
      case (s1_item_r.next_action)
        cpexc_pkg::ACT_JUMP: begin
          bd_val  = 1'b0;
          epc_val = s1_item_r.jump_target;
        end
        cpexc_pkg::ACT_DELAY: begin
          bd_val  = 1'b1;
          epc_val = s1_item_r.current_pc;
        end
        default: begin
          bd_val  = 1'b0;
          epc_val = s1_item_r.current_pc + 32'd4;
        end
      endcase
    end

    status_nxt  = status_mid;
    cause_nxt   = cause_mid;
    epc_nxt     = epc_r;
    badaddr_nxt = badaddr_r;
    if (taken) begin
      // push the ku/ie stack, bits above it are kept
      status_nxt        = {status_mid[31:6], status_mid[3:0], 2'b00};
      cause_nxt[31]     = bd_val;
      cause_nxt[29:28]  = ce;
      cause_nxt[6:2]    = code;
      epc_nxt           = epc_val;
    end
    if ((s1_item_r.mode == cpexc_pkg::MODE_RAISE) &&
        (s1_item_r.exc_kind == cpexc_pkg::KIND_ADDR)) begin
      badaddr_nxt = s1_item_r.fault_address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r  <= cpexc_pkg::STATUS_RESET;
      cause_r   <= '0;
      epc_r     <= '0;
      badaddr_r <= '0;
    end else if (fire) begin
      status_r  <= status_nxt;
      cause_r   <= cause_nxt;
      epc_r     <= epc_nxt;
      badaddr_r <= badaddr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_taken_r   <= taken;
      out_handler_r <= !taken ? 32'd0 :
                       (status_mid[cpexc_pkg::SR_BEV_BIT] ? cpexc_pkg::VEC_BOOT
                                                          : cpexc_pkg::VEC_KSEG0);
    end
  end

  // register values in the result are the architectural registers themselves
  assign out_valid           = out_valid_r;
  assign out_exception_taken = out_taken_r;
  assign out_handler_address = out_handler_r;
  assign out_epc_out         = epc_r;
  assign out_cause_out       = cause_r;
  assign out_status_out      = status_r;
  assign out_bad_address_out = badaddr_r;

`ifndef SYNTH
  // a delivered entry always points at one of the two vectors
  a_vec_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exception_taken |->
      (out_handler_address == cpexc_pkg::VEC_BOOT) ||
      (out_handler_address == cpexc_pkg::VEC_KSEG0))
    else $error("handler vector not a legal entry point");

  // no entry means no vector
  a_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_exception_taken |-> out_handler_address == 32'd0)
    else $error("vector given without an entry");

  // an entry leaves kernel mode with interrupts off
  a_entry_kuie: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exception_taken |-> out_status_out[1:0] == 2'b00)
    else $error("ku/ie stack not pushed on entry");

  // a clear transaction never enters anything
  a_clear_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (s1_item_r.mode == cpexc_pkg::MODE_IRQ_CLEAR) |=> !out_exception_taken)
    else $error("entry taken on a pending clear");
`endif

endmodule

/* verif/coprocessor_exception_unit_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of the coprocessor exception unit with its own register predictor
module coprocessor_exception_unit_tb;

  // exception kind that has no meaning and must leave every register alone
  localparam logic [2:0] KIND_UNDEFINED = 3'd7;
  // lowest bit of the pending interrupt field in the cause register
  localparam int IP_LSB = 8;
  // bit position of the cause register BD field that an entry rewrites
  localparam int CAUSE_BD_BIT = 31;
  // random transactions per idling phase, four phases in all
  localparam int RANDOM_PER_PHASE = 163;

  // one result transaction as the block presents it
  typedef struct packed {
    logic        taken;
    logic [31:0] handler;
    logic [31:0] epc;
    logic [31:0] cause;
    logic [31:0] status;
    logic [31:0] bad_address;
  } exc_result_t;

  // predicts the cp0 registers after every accepted transaction and checks each result
  class exc_scoreboard;
    logic [31:0]  status_r;
    logic [31:0]  cause_r;
    logic [31:0]  epc_r;
    logic [31:0]  bad_addr_r;
    exc_result_t  expected_results[$];
    int unsigned  mismatches;

    function new();
      status_r   = cpexc_pkg::STATUS_RESET;
      cause_r    = '0;
      epc_r      = '0;
      bad_addr_r = '0;
      mismatches = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // exception entry: code and ce, push of the ku/ie stack, epc and bd, vector choice
    function logic [31:0] enter_exception(logic [4:0] code, logic [1:0] ce,
                                          logic [31:0] pc, logic delay);
      logic [5:0] stack;
      stack           = status_r[5:0];
      cause_r[6:2]    = code;
      cause_r[29:28]  = ce;
      status_r[5:0]   = {stack[3:0], 2'b00};
      if (delay) begin
        epc_r                 = pc - 32'd4;
        cause_r[CAUSE_BD_BIT] = 1'b1;
      end else begin
        epc_r                 = pc;
        cause_r[CAUSE_BD_BIT] = 1'b0;
      end
      return status_r[cpexc_pkg::SR_BEV_BIT] ? cpexc_pkg::VEC_BOOT : cpexc_pkg::VEC_KSEG0;
    endfunction

    // interrupt entry when iec is set and some pending line is unmasked
    function logic irq_entry(logic [31:0] pc, logic [1:0] action, logic [31:0] target,
                             output logic [31:0] vec);
      vec = '0;
      if (!status_r[0] || (status_r[15:8] & cause_r[15:8]) == 8'h00)
        return 1'b0;
      if (action == cpexc_pkg::ACT_JUMP)
        vec = enter_exception(cpexc_pkg::EXC_INT, 2'b00, target, 1'b0);
      else
        vec = enter_exception(cpexc_pkg::EXC_INT, 2'b00, pc + 32'd4,
                              action == cpexc_pkg::ACT_DELAY);
      return 1'b1;
    endfunction

    function void note_input(cpexc_pkg::item_t it);
      exc_result_t r;
      logic [4:0]  code;
      logic [1:0]  ce;
      logic        taken;
      logic [31:0] vec;
      taken = 1'b0;
      vec   = '0;
      code  = cpexc_pkg::EXC_INT;
      ce    = 2'b00;
      case (it.mode)
        cpexc_pkg::MODE_RAISE: begin
          taken = 1'b1;
          case (it.exc_kind)
            cpexc_pkg::KIND_ADDR: begin
              code       = it.is_load ? cpexc_pkg::EXC_ADEL : cpexc_pkg::EXC_ADES;
              bad_addr_r = it.fault_address;
            end
            cpexc_pkg::KIND_BUS:
              code = it.from_fetch ? cpexc_pkg::EXC_IBE : cpexc_pkg::EXC_DBE;
            cpexc_pkg::KIND_OVF:      code = cpexc_pkg::EXC_OV;
            cpexc_pkg::KIND_SYSCALL:  code = cpexc_pkg::EXC_SYS;
            cpexc_pkg::KIND_BREAK:    code = cpexc_pkg::EXC_BP;
            cpexc_pkg::KIND_RESERVED: code = cpexc_pkg::EXC_RI;
            cpexc_pkg::KIND_COP_UNUS: begin
              code = cpexc_pkg::EXC_CPU;
              ce   = it.coproc_index;
            end
            default:       taken = 1'b0;
          endcase
          if (taken)
            vec = enter_exception(code, ce, it.current_pc, it.in_delay_slot);
        end
        cpexc_pkg::MODE_IRQ_SET: begin
          cause_r[IP_LSB + it.irq_line] = 1'b1;
          taken = irq_entry(it.current_pc, it.next_action, it.jump_target, vec);
        end
        cpexc_pkg::MODE_IRQ_CLEAR: cause_r[IP_LSB + it.irq_line] = 1'b0;
        cpexc_pkg::MODE_STATUS_WR: begin
          status_r = it.status_write_value;
          taken = irq_entry(it.current_pc, it.next_action, it.jump_target, vec);
        end
        default: ;
      endcase
      r.taken       = taken;
      r.handler     = vec;
      r.epc         = epc_r;
      r.cause       = cause_r;
      r.status      = status_r;
      r.bad_address = bad_addr_r;
      expected_results.push_back(r);
    endfunction

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_result(exc_result_t got);
      exc_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding");
        return;
      end
      want = expected_results.pop_front();
      compare_field("exception_taken", 32'(got.taken), 32'(want.taken));
      compare_field("handler_address", got.handler, want.handler);
      compare_field("epc", got.epc, want.epc);
      compare_field("cause", got.cause, want.cause);
      compare_field("status", got.status, want.status);
      compare_field("bad_address", got.bad_address, want.bad_address);
    endtask
  endclass

  // every block input starts at a known value
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = '0;
  logic [2:0]  in_exc_kind = '0;
  logic [31:0] in_fault_address = '0;
  logic        in_from_fetch = 1'b0;
  logic        in_is_load = 1'b0;
  logic [1:0]  in_coproc_index = '0;
  logic [2:0]  in_irq_line = '0;
  logic [31:0] in_status_write_value = '0;
  logic [31:0] in_current_pc = '0;
  logic [1:0]  in_next_action = '0;
  logic [31:0] in_jump_target = '0;
  logic        in_in_delay_slot = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_exception_taken;
  logic [31:0] out_handler_address;
  logic [31:0] out_epc_out;
  logic [31:0] out_cause_out;
  logic [31:0] out_status_out;
  logic [31:0] out_bad_address_out;

  // percentages of cycles in which the sender idles and the receiver stalls
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  exc_scoreboard cp0_model = new();

  coprocessor_exception_unit i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_mode               (in_mode),
    .in_exc_kind           (in_exc_kind),
    .in_fault_address      (in_fault_address),
    .in_from_fetch         (in_from_fetch),
    .in_is_load            (in_is_load),
    .in_coproc_index       (in_coproc_index),
    .in_irq_line           (in_irq_line),
    .in_status_write_value (in_status_write_value),
    .in_current_pc         (in_current_pc),
    .in_next_action        (in_next_action),
    .in_jump_target        (in_jump_target),
    .in_in_delay_slot      (in_in_delay_slot),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_exception_taken   (out_exception_taken),
    .out_handler_address   (out_handler_address),
    .out_epc_out           (out_epc_out),
    .out_cause_out         (out_cause_out),
    .out_status_out        (out_status_out),
    .out_bad_address_out   (out_bad_address_out)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, re-rolled every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // both handshakes are sampled at the edge, before any of this edge's drives land
  always @(posedge clk) begin : port_monitor
    cpexc_pkg::item_t seen_in;
    exc_result_t      seen_out;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        seen_in.mode               = in_mode;
        seen_in.exc_kind           = in_exc_kind;
        seen_in.fault_address      = in_fault_address;
        seen_in.from_fetch         = in_from_fetch;
        seen_in.is_load            = in_is_load;
        seen_in.coproc_index       = in_coproc_index;
        seen_in.irq_line           = in_irq_line;
        seen_in.status_write_value = in_status_write_value;
        seen_in.current_pc         = in_current_pc;
        seen_in.next_action        = in_next_action;
        seen_in.jump_target        = in_jump_target;
        seen_in.in_delay_slot      = in_in_delay_slot;
        cp0_model.note_input(seen_in);
      end
      if (out_valid && out_ready) begin
        seen_out.taken       = out_exception_taken;
        seen_out.handler     = out_handler_address;
        seen_out.epc         = out_epc_out;
        seen_out.cause       = out_cause_out;
        seen_out.status      = out_status_out;
        seen_out.bad_address = out_bad_address_out;
        cp0_model.check_result(seen_out);
      end
    end
  end

  // random transaction: raises dominate, status writes usually enable interrupts
  // so that pending lines actually get taken
  function automatic cpexc_pkg::item_t random_item();
    cpexc_pkg::item_t it;
    int unsigned      pick;
    pick = $urandom_range(99);
    if (pick < 40)
      it.mode = cpexc_pkg::MODE_RAISE;
    else if (pick < 62)
      it.mode = cpexc_pkg::MODE_IRQ_SET;
    else if (pick < 80)
      it.mode = cpexc_pkg::MODE_IRQ_CLEAR;
    else
      it.mode = cpexc_pkg::MODE_STATUS_WR;
    it.exc_kind = ($urandom_range(19) == 0) ? KIND_UNDEFINED : 3'($urandom_range(6));
    it.fault_address      = $urandom();
    it.from_fetch         = 1'($urandom_range(1));
    it.is_load            = 1'($urandom_range(1));
    it.coproc_index       = 2'($urandom_range(3));
    it.irq_line           = 3'($urandom_range(7));
    it.status_write_value = $urandom();
    if ($urandom_range(9) < 6)
      it.status_write_value[0] = 1'b1;
    it.current_pc         = $urandom();
    it.next_action        = 2'($urandom_range(3));
    it.jump_target        = $urandom();
    it.in_delay_slot      = 1'($urandom_range(1));
    return it;
  endfunction

  // offer one transaction, with random idle cycles first, and hold it until taken
  task send_item(cpexc_pkg::item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_mode               <= it.mode;
    in_exc_kind           <= it.exc_kind;
    in_fault_address      <= it.fault_address;
    in_from_fetch         <= it.from_fetch;
    in_is_load            <= it.is_load;
    in_coproc_index       <= it.coproc_index;
    in_irq_line           <= it.irq_line;
    in_status_write_value <= it.status_write_value;
    in_current_pc         <= it.current_pc;
    in_next_action        <= it.next_action;
    in_jump_target        <= it.jump_target;
    in_in_delay_slot      <= it.in_delay_slot;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
  endtask

  // sender holds off until every outstanding result has come back; the first
  // edge lets the monitor log the last accepted transaction
  task drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cp0_model.expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    cpexc_pkg::item_t it;
    int               idle_plan[4];
    int               stall_plan[4];
    idle_plan  = '{0, 78, 0, 18};
    stall_plan = '{0, 0, 78, 18};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, starting from reset state (bev set, interrupts off)
    // address error on a load in a delay slot at pc zero: epc wraps
    it = random_item(); it.mode = cpexc_pkg::MODE_RAISE;
    it.exc_kind = cpexc_pkg::KIND_ADDR; it.is_load = 1'b1;
    it.fault_address = '0; it.current_pc = '0; it.in_delay_slot = 1'b1; send_item(it);
    // address error on a store, all-ones address and pc
    it = random_item(); it.mode = cpexc_pkg::MODE_RAISE;
    it.exc_kind = cpexc_pkg::KIND_ADDR; it.is_load = 1'b0;
    it.fault_address = '1; it.current_pc = '1; it.in_delay_slot = 1'b0; send_item(it);
    // bus errors from fetch and from data
    it = random_item(); it.mode = cpexc_pkg::MODE_RAISE;
    it.exc_kind = cpexc_pkg::KIND_BUS; it.from_fetch = 1'b1;
    send_item(it);
    it = random_item(); it.mode = cpexc_pkg::MODE_RAISE;
    it.exc_kind = cpexc_pkg::KIND_BUS; it.from_fetch = 1'b0;
    send_item(it);
    // remaining kinds; ce must stay zero even with a coprocessor number offered
    it = random_item(); it.mode = cpexc_pkg::MODE_RAISE;
    it.exc_kind = cpexc_pkg::KIND_OVF; it.coproc_index = 2'd3;
    send_item(it);
    it = random_item(); it.mode = cpexc_pkg::MODE_RAISE;
    it.exc_kind = cpexc_pkg::KIND_SYSCALL; send_item(it);
    it = random_item(); it.mode = cpexc_pkg::MODE_RAISE;
    it.exc_kind = cpexc_pkg::KIND_BREAK; send_item(it);
    it = random_item(); it.mode = cpexc_pkg::MODE_RAISE;
    it.exc_kind = cpexc_pkg::KIND_RESERVED; send_item(it);
    // coprocessor unusable carries its index into ce
    it = random_item(); it.mode = cpexc_pkg::MODE_RAISE;
    it.exc_kind = cpexc_pkg::KIND_COP_UNUS; it.coproc_index = 2'd3; send_item(it);
    it = random_item(); it.mode = cpexc_pkg::MODE_RAISE;
    it.exc_kind = cpexc_pkg::KIND_COP_UNUS; it.coproc_index = 2'd0; send_item(it);
    // undefined kind is ignored
    it = random_item(); it.mode = cpexc_pkg::MODE_RAISE; it.exc_kind = KIND_UNDEFINED;
    send_item(it);
    // pending line 7 with interrupts disabled: nothing taken
    it = random_item(); it.mode = cpexc_pkg::MODE_IRQ_SET; it.irq_line = 3'd7;
    send_item(it);
    // enabling with everything unmasked takes it; resume pc wraps past all-ones
    it = random_item(); it.mode = cpexc_pkg::MODE_STATUS_WR;
    it.status_write_value = 32'h0000_ff01;
    it.current_pc = '1; it.next_action = cpexc_pkg::ACT_CONTINUE; send_item(it);
    // bev set again, resume into the delay slot
    it = random_item(); it.mode = cpexc_pkg::MODE_STATUS_WR;
    it.status_write_value = 32'h0040_8001;
    it.next_action = cpexc_pkg::ACT_DELAY; send_item(it);
    // resume at the jump target
    it = random_item(); it.mode = cpexc_pkg::MODE_STATUS_WR;
    it.status_write_value = 32'h0000_8001;
    it.next_action = cpexc_pkg::ACT_JUMP; it.jump_target = '1; send_item(it);
    // undefined next action behaves as continue
    it = random_item(); it.mode = cpexc_pkg::MODE_STATUS_WR;
    it.status_write_value = 32'h0000_8001;
    it.next_action = 2'($urandom_range(3, 3)); send_item(it);
    it = random_item(); it.mode = cpexc_pkg::MODE_IRQ_CLEAR; it.irq_line = 3'd7;
    send_item(it);
    // full ku/ie stack with nothing pending: no entry
    it = random_item(); it.mode = cpexc_pkg::MODE_STATUS_WR;
    it.status_write_value = 32'h0000_ff3f;
    send_item(it);
    // setting line 0 now enters, pushing the full stack and dropping its top
    it = random_item(); it.mode = cpexc_pkg::MODE_IRQ_SET; it.irq_line = 3'd0;
    send_item(it);
    // interrupts now off after the push
    it = random_item(); it.mode = cpexc_pkg::MODE_IRQ_SET; it.irq_line = 3'd7;
    send_item(it);
    // clearing a line never enters, clearing one not pending changes nothing
    it = random_item(); it.mode = cpexc_pkg::MODE_IRQ_CLEAR; it.irq_line = 3'd0;
    send_item(it);
    it = random_item(); it.mode = cpexc_pkg::MODE_IRQ_CLEAR; it.irq_line = 3'd3;
    send_item(it);
    // all-ones status write: enabled, line 7 still pending, boot vector
    it = random_item(); it.mode = cpexc_pkg::MODE_STATUS_WR; it.status_write_value = '1;
    send_item(it);
    it = random_item(); it.mode = cpexc_pkg::MODE_STATUS_WR; it.status_write_value = '0;
    send_item(it);
    it = random_item(); it.mode = cpexc_pkg::MODE_RAISE;
    it.exc_kind = cpexc_pkg::KIND_SYSCALL; it.in_delay_slot = 1'b1; send_item(it);
    drain_results();

    // random part, one idling phase after another, fully drained in between
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_plan[phase];
      stall_pct = stall_plan[phase];
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_item(random_item());
      drain_results();
    end

    stall_pct = 0;
    repeat (8) @(posedge clk);
    if (cp0_model.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
design/cpexc_pkg.sv
design/coprocessor_exception_unit.sv
verif/coprocessor_exception_unit_tb.sv
